>>> src/scd_pkg.sv
// Package for the scene change detector: widths, register map and shared types.
// Used by every module under src.
package scd_pkg;

    localparam int MAX_SAMPLES = 1048576;
    localparam int SAMPLE_BITS = 12;

    localparam int QW        = 23;
    localparam int CNTW      = 21;
    localparam int DEPTHW    = 4;
    localparam int SUMW      = 32;
    localparam int ADDRW     = 4;

    localparam logic [QW-1:0] MAFD_MAX  = 23'h7FFFFF;
    localparam logic [QW-1:0] SCORE_MAX = 23'd6553600;

    localparam logic [ADDRW-1:0] REG_THRESHOLD = 4'h0;
    localparam logic [ADDRW-1:0] REG_PASS_ONLY = 4'h4;
    localparam logic [ADDRW-1:0] REG_BIT_DEPTH = 4'h8;
    localparam logic [ADDRW-1:0] REG_SAMPLE_CNT = 4'hC;

    // End-of-frame job handed from the accumulator to the scoring unit
    typedef struct packed {
        logic [SUMW-1:0] sum;
        logic            valid_frame;
    } scd_job_t;

    // Configuration seen by the scoring unit
    typedef struct packed {
        logic [QW-1:0]     threshold;
        logic              pass_only;
        logic [DEPTHW-1:0] bit_depth;
        logic [CNTW-1:0]   sample_count;
    } scd_cfg_t;

endpackage

>>> src/scene_change_detector_unit.sv
// Scene change detector top level: APB registers, front accumulator, back scorer.
// Depends on scd_pkg, scd_front, scd_back.
// Throughput: one sample per cycle while s_tready is high; the scorer runs a serial
// division per frame, one frame end can wait for it, a second stalls s_tready.
// Reset: rst_n asynchronous, clears control state and registers to defaults;
// the frame memory is not cleared, the first frame after reset scores 0.
module scene_change_detector_unit
    import scd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [ADDRW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [11:0] sample_value
    input  logic             s_tlast,   // frame_end
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,   // [22:0] score, [45:23] mafd
    output logic [1:0]       m_tuser    // [0] scene_change, [1] forward_frame
);

    scd_cfg_t cfg_reg;
    logic     clear;
    logic     wr;
    logic     job_valid, job_ready;
    scd_job_t job;
    logic [QW-1:0] score, mafd;
    logic chg, fwd;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign clear  = wr && (paddr == REG_SAMPLE_CNT);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= 23'd655360;
            cfg_reg.pass_only    <= 1'b0;
            cfg_reg.bit_depth    <= 4'd8;
            cfg_reg.sample_count <= 21'd1048576;
        end
        else if (wr)
        begin
            case (paddr)
                REG_THRESHOLD:  cfg_reg.threshold    <= pwdata[QW-1:0];
                REG_PASS_ONLY:  cfg_reg.pass_only    <= pwdata[0];
                REG_BIT_DEPTH:  cfg_reg.bit_depth    <= pwdata[DEPTHW-1:0];
                REG_SAMPLE_CNT: cfg_reg.sample_count <= pwdata[CNTW-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (paddr)
            REG_THRESHOLD:  prdata = 32'(cfg_reg.threshold);
            REG_PASS_ONLY:  prdata = 32'(cfg_reg.pass_only);
            REG_BIT_DEPTH:  prdata = 32'(cfg_reg.bit_depth);
            REG_SAMPLE_CNT: prdata = 32'(cfg_reg.sample_count);
            default:        prdata = '0;
        endcase
    end

    scd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .sample_value (s_tdata[SAMPLE_BITS-1:0]),
        .frame_end    (s_tlast),
        .clear        (clear),
        .sample_count (cfg_reg.sample_count),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job)
    );

    scd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job           (job),
        .cfg           (cfg_reg),
        .clear         (clear),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .score         (score),
        .mafd          (mafd),
        .scene_change  (chg),
        .forward_frame (fwd)
    );

    assign m_tdata = {2'b00, mafd, score};
    assign m_tuser = {fwd, chg};

endmodule

>>> src/scd_front.sv
// Front part: frame memory, absolute difference sum, frame length check.
// Depends on scd_pkg.
module scd_front
    import scd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample_value,
    input  logic                   frame_end,
    input  logic                   clear,
    input  logic [CNTW-1:0]        sample_count,
    output logic                   job_valid,
    input  logic                   job_ready,
    output scd_job_t               job
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int IW = AW + 1;
    localparam int DW = SAMPLE_BITS;

    // Frame memory: read into stage 1, written back from stage 1 as its sample moves on
    logic [DW-1:0] mem [MAX_SAMPLES];

    logic [IW-1:0]   index_reg, index_next;
    logic            s1_valid_reg;
    logic            s1_end_reg;
    logic            s1_inrange_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic [DW-1:0]   s1_value_reg;
    logic [DW-1:0]   s1_old_reg;
    logic            s1_byp_reg;
    logic [DW-1:0]   s1_byp_value_reg;
    logic [IW-1:0]   s1_len_reg;
    logic [SUMW-1:0] sum_reg, sum_next;
    logic            job_valid_reg;
    scd_job_t        job_reg;

    logic take;
    logic s1_stall;
    logic s1_adv;
    logic [DW-1:0] old_value;
    logic [DW-1:0] absdiff;
    logic [SUMW-1:0] sum_add;
    logic inrange;
    logic len_ok;

    // A frame end in stage 1 waits while the job slot is still full
    assign s1_stall = s1_valid_reg && s1_end_reg && job_valid_reg && !job_ready;
    assign s1_adv   = s1_valid_reg && !s1_stall;
    assign in_ready = !s1_stall;
    assign take     = in_valid && in_ready;
    assign inrange  = index_reg < IW'(MAX_SAMPLES);

    always_comb
    begin
        index_next = index_reg;
        if (take)
        begin
            if (frame_end)
                index_next = '0;
            else if (index_reg <= IW'(MAX_SAMPLES))
                index_next = index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            index_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            index_reg    <= index_next;
            s1_valid_reg <= take || s1_stall;
        end
    end

    // Stage 1 payload and memory read; the sample written back at the same
    // edge to the same address is forwarded instead of the stale read
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_end_reg       <= frame_end;
            s1_inrange_reg   <= inrange;
            s1_addr_reg      <= index_reg[AW-1:0];
            s1_value_reg     <= DW'(sample_value);
            s1_len_reg       <= (index_reg <= IW'(MAX_SAMPLES)) ? index_reg + 1'b1 : index_reg;
            s1_old_reg       <= mem[index_reg[AW-1:0]];
            s1_byp_reg       <= s1_valid_reg && s1_inrange_reg
                             && (s1_addr_reg == index_reg[AW-1:0]);
            s1_byp_value_reg <= s1_value_reg;
        end
    end

    // Write back once the stage 1 sample moves on
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_inrange_reg && !clear)
            mem[s1_addr_reg] <= s1_value_reg;
    end

    assign old_value = s1_byp_reg ? s1_byp_value_reg : s1_old_reg;
    assign absdiff = (s1_value_reg > old_value) ? s1_value_reg - old_value
                                                : old_value - s1_value_reg;
    assign sum_add = sum_reg + (s1_inrange_reg ? SUMW'(absdiff) : '0);
    assign len_ok  = (sample_count != '0) && (32'(s1_len_reg) == 32'(sample_count))
                  && (32'(sample_count) <= 32'(MAX_SAMPLES));

    always_comb
    begin
        sum_next = sum_reg;
        if (s1_adv)
            sum_next = s1_end_reg ? '0 : sum_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= clear ? '0 : sum_next;
            if (s1_adv && s1_end_reg && !clear)
                job_valid_reg <= 1'b1;
            else if (job_ready)
                job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_end_reg)
        begin
            job_reg.sum         <= sum_add;
            job_reg.valid_frame <= len_ok;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

>>> src/scd_back.sv
// Back part: serial divider for mafd, score, flags and output register.
// Depends on scd_pkg.
module scd_back
    import scd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  scd_job_t      job,
    input  scd_cfg_t      cfg,
    input  logic          clear,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [QW-1:0] score,
    output logic [QW-1:0] mafd,
    output logic          scene_change,
    output logic          forward_frame
);

    localparam int NUMW = SUMW + 23;   // sum * 100 * 2^16
    localparam int DENW = CNTW + 12 + 4;
    localparam int CW   = $clog2(NUMW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [CW-1:0]   cnt_reg;
    logic [NUMW-1:0] quo_reg;
    logic [DENW:0]   rem_reg;
    logic [DENW-1:0] den_reg;
    logic [SUMW-1:0] sum_reg;
    logic            hp_reg;
    logic            vf_reg;
    logic [QW-1:0]   last_reg;
    logic            ov_reg;
    logic [QW-1:0]   score_reg, mafd_reg;
    logic            chg_reg, fwd_reg;

    logic [DENW:0]   trial;
    logic [QW-1:0]   m_new, diff, mn, sc;
    logic            chg;

    assign job_ready = (state_reg == ST_IDLE) && !(ov_reg && !out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (job_valid && job_ready) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Restoring division, one quotient bit a cycle
    assign trial = {rem_reg[DENW-1:0], quo_reg[NUMW-1]} - {1'b0, den_reg};

    assign m_new = (quo_reg > NUMW'(MAFD_MAX)) ? MAFD_MAX : quo_reg[QW-1:0];
    assign diff  = (m_new > last_reg) ? m_new - last_reg : last_reg - m_new;
    assign mn    = (m_new < diff) ? m_new : diff;
    assign sc    = (hp_reg && vf_reg) ? ((mn > SCORE_MAX) ? SCORE_MAX : mn) : '0;
    assign chg   = sc >= cfg.threshold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hp_reg    <= 1'b0;
            last_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN)
            begin
                if (hp_reg && vf_reg)
                    last_reg <= m_new;
                hp_reg <= vf_reg;
                ov_reg <= 1'b1;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
            if (clear)
                hp_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sum_reg <= job.sum;
                vf_reg  <= job.valid_frame;
            end
            ST_MUL:
            begin
                // sum * 100 * 2^16 = sum * (2^22 + 2^21 + 2^18)
                quo_reg <= (NUMW'(sum_reg) << 22) + (NUMW'(sum_reg) << 21)
                         + (NUMW'(sum_reg) << 18);
                rem_reg <= '0;
                den_reg <= DENW'(cfg.sample_count) << cfg.bit_depth;
                cnt_reg <= CW'(NUMW - 1);
            end
            ST_DIV:
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (!trial[DENW])
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[NUMW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DENW-1:0], quo_reg[NUMW-1]};
                    quo_reg <= {quo_reg[NUMW-2:0], 1'b0};
                end
            end
            ST_FIN:
            begin
                score_reg <= sc;
                mafd_reg  <= (hp_reg && vf_reg) ? m_new : last_reg;
                chg_reg   <= chg;
                fwd_reg   <= !cfg.pass_only || chg;
            end
            default: ;
        endcase
    end

    assign out_valid     = ov_reg;
    assign score         = score_reg;
    assign mafd          = mafd_reg;
    assign scene_change  = chg_reg;
    assign forward_frame = fwd_reg;

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !job_ready) else $error("job taken while busy");
    a_score_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (score_reg <= SCORE_MAX)) else $error("score above cap");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg) else $error("result dropped");
`endif

endmodule
